FILE: rtl/core/keypad_debounce_key_queue_assert.svh
// assertion macros for the keypad debounce key queue
`ifndef KEYPAD_DEBOUNCE_KEY_QUEUE_ASSERT_SVH
`define KEYPAD_DEBOUNCE_KEY_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF
`define KDKQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KDKQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KDKQ_ASSERT(lbl, prop, msg)
`define KDKQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/kdkq_pkg.sv
// shared types and constants for the keypad debounce key queue
package kdkq_pkg;

  localparam int unsigned NUM_KEYS = 5;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned IDX_W    = 3;

  localparam logic [NUM_KEYS-1:0] KEY_MASK = 5'h1f;
  localparam logic [IDX_W-1:0]    LAST_KEY = 3'd4;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_POP_RD  = 5'b00100,
    ST_POP_DAT = 5'b01000,
    ST_FINISH  = 5'b10000
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic pop_read;
    logic pop_take;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

FILE: rtl/core/keypad_debounce_key_queue.sv
// top level of the keypad debounce key queue
//
//  channel  valid      ready      fields
//  input    in_valid   in_ready   mode, pin_levels
//  output   out_valid  out_ready  key_code, keys_waiting
//
// a sample transaction steps through accept, a scan step per key line to push codes, then finish
// a pop transaction steps through accept, ring read, registered read data, then finish
// the ring ram has one write and one registered read port, one code per cycle
// reset clears both key sets and the ring pointers; the ring itself is not cleared
// a new transaction is taken while a result waits; finish stalls while a result waits and out_ready is low
module keypad_debounce_key_queue
  import kdkq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic [NUM_KEYS-1:0] pin_levels,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CODE_W-1:0]   key_code,
  output logic                keys_waiting
);

  cmd_t cmd;
  sts_t sts;

  kdkq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  kdkq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .mode         (mode),
    .pin_levels   (pin_levels),
    .key_code     (key_code),
    .keys_waiting (keys_waiting)
  );

endmodule

FILE: rtl/core/kdkq_ram.sv
// generic simple dual port ram with registered read
module kdkq_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/kdkq_ctrl.sv
// controller state machine for the keypad debounce key queue
`include "keypad_debounce_key_queue_assert.svh"

module kdkq_ctrl
  import kdkq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic mode,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = (mode == MODE_POP) ? ST_POP_RD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_POP_RD: begin
        cmd.pop_read = 1'b1;
        state_next   = ST_POP_DAT;
      end
      ST_POP_DAT: begin
        cmd.pop_take = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `KDKQ_ASSERT(a_load_slot_free, cmd.load_out |-> (!out_valid || out_ready), "result overwritten")
  `KDKQ_ASSERT_NEXT(a_scan_ends, (state == ST_SCAN) && sts.scan_last, state == ST_FINISH, "scan overrun")
  `KDKQ_ASSERT_NEXT(a_pop_reads, in_valid && in_ready && (mode == MODE_POP), state == ST_POP_RD, "pop lost")
  `KDKQ_ASSERT_NEXT(a_load_gives_valid, cmd.load_out, out_valid, "result not shown")

endmodule

FILE: rtl/core/kdkq_dp.sv
// datapath with key sets, ring pointers and code ring for the keypad debounce key queue
`include "keypad_debounce_key_queue_assert.svh"

module kdkq_dp
  import kdkq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                mode,
  input  logic [NUM_KEYS-1:0] pin_levels,
  output logic [CODE_W-1:0]   key_code,
  output logic                keys_waiting
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [NUM_KEYS-1:0] accepted_keys;
  logic [NUM_KEYS-1:0] previous_sample;
  logic [NUM_KEYS-1:0] pending;
  logic [PTR_W-1:0]    read_pointer;
  logic [PTR_W-1:0]    write_pointer;
  logic [IDX_W-1:0]    idx;
  logic [CODE_W-1:0]   code;

  logic [NUM_KEYS-1:0] held;
  logic                hit;
  logic [PTR_W-1:0]    read_pointer_next;
  logic [PTR_W-1:0]    write_pointer_next;
  logic                empty;
  logic                full;
  logic                push;
  logic [CODE_W-1:0]   push_code;
  logic [CODE_W-1:0]   ram_rdata;

  always_comb begin
    held               = (~pin_levels) & KEY_MASK;
    hit                = (held == previous_sample) && (held != accepted_keys);
    read_pointer_next  = (read_pointer == PTR_LAST) ? '0 : read_pointer + 1'b1;
    write_pointer_next = (write_pointer == PTR_LAST) ? '0 : write_pointer + 1'b1;
    empty              = (read_pointer == write_pointer);
    full               = (write_pointer_next == read_pointer);
    push               = cmd.scan_step && pending[idx] && !full;
    push_code          = CODE_W'(idx) + 1'b1;
    sts.scan_last      = (idx == LAST_KEY);
  end

  kdkq_ram #(
    .WIDTH (CODE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (push),
    .waddr (write_pointer),
    .wdata (push_code),
    .re    (cmd.pop_read),
    .raddr (read_pointer),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_keys   <= '0;
      previous_sample <= '0;
      read_pointer    <= '0;
      write_pointer   <= '0;
    end else begin
      if (cmd.accept && (mode == MODE_SAMPLE)) begin
        previous_sample <= held;
        if (hit) begin
          accepted_keys <= held;
        end
      end
      if (push) begin
        write_pointer <= write_pointer_next;
      end
      if (cmd.pop_take && !empty) begin
        read_pointer <= read_pointer_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx  <= '0;
      code <= '0;
      if ((mode == MODE_SAMPLE) && hit) begin
        pending <= held & ~accepted_keys;
      end else begin
        pending <= '0;
      end
    end
    if (cmd.scan_step) begin
      idx <= idx + 1'b1;
    end
    if (cmd.pop_take && !empty) begin
      code <= ram_rdata;
    end
    if (cmd.load_out) begin
      key_code     <= code;
      keys_waiting <= !empty;
    end
  end

  `KDKQ_ASSERT(a_rd_in_range, read_pointer <= PTR_LAST, "read pointer out of range")
  `KDKQ_ASSERT(a_wr_in_range, write_pointer <= PTR_LAST, "write pointer out of range")
  `KDKQ_ASSERT_NEXT(a_wr_only_on_push, !push, $stable(write_pointer), "write pointer moved")

endmodule

FILE: sim/tb_keypad_debounce_key_queue.sv
`timescale 1ns / 100ps
// testbench for the keypad debounce key queue: directed and random transactions, predicted results
module tb_keypad_debounce_key_queue;
  import kdkq_pkg::*;

  localparam int DEPTH       = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              waiting;
  } key_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                mode = MODE_SAMPLE;
  logic [NUM_KEYS-1:0] pin_levels = '1;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CODE_W-1:0]   key_code;
  logic                keys_waiting;

  key_result_t         key_results_due[$];
  int                  error_count = 0;
  int                  items_sent = 0;
  int                  cycle_count = 0;
  int                  hold_cycles = 0;
  bit                  idle_on = 1'b1;

  logic [NUM_KEYS-1:0] model_accepted = '0;
  logic [NUM_KEYS-1:0] model_prev = '0;
  logic [CODE_W-1:0]   model_ring[DEPTH];
  int                  model_rd = 0;
  int                  model_wr = 0;

  keypad_debounce_key_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .pin_levels   (pin_levels),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .key_code     (key_code),
    .keys_waiting (keys_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic key_result_t predict_key_step(input logic m,
                                                   input logic [NUM_KEYS-1:0] pins);
    key_result_t         r;
    logic [NUM_KEYS-1:0] held;
    int                  nxt;
    r.code = '0;
    if (m == MODE_SAMPLE) begin
      held = ~pins & KEY_MASK;
      if (held == model_prev && held != model_accepted) begin
        for (int i = 0; i < NUM_KEYS; i++) begin
          if (held[i] && !model_accepted[i]) begin
            nxt = (model_wr + 1) % DEPTH;
            if (nxt != model_rd) begin
              model_ring[model_wr] = CODE_W'(i + 1);
              model_wr = nxt;
            end
          end
        end
        model_accepted = held;
      end
      model_prev = held;
    end else if (model_rd != model_wr) begin
      r.code = model_ring[model_rd];
      model_rd = (model_rd + 1) % DEPTH;
    end
    r.waiting = (model_rd != model_wr);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic send_item(input logic m, input logic [NUM_KEYS-1:0] pins);
    while (idle_on && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    pin_levels <= pins;
    do @(posedge clk); while (!(in_valid && in_ready));
    key_results_due.push_back(predict_key_step(m, pins));
    items_sent++;
  endtask

  task automatic sample_keys(input logic [NUM_KEYS-1:0] held, input int repeats);
    repeat (repeats) send_item(MODE_SAMPLE, ~held);
  endtask

  task automatic pop_keys(input int count);
    repeat (count) send_item(MODE_POP, NUM_KEYS'($urandom_range(0, 31)));
  endtask

  task automatic test_pop_empty();
    send_item(MODE_POP, 5'h00);
    send_item(MODE_POP, 5'h1f);
  endtask

  task automatic test_single_press();
    sample_keys(5'b00001, 2);
    pop_keys(1);
  endtask

  task automatic test_unstable();
    send_item(MODE_SAMPLE, 5'h1e);
    send_item(MODE_SAMPLE, 5'h1d);
    send_item(MODE_SAMPLE, 5'h1b);
  endtask

  // two full presses overflow the ring, then drain past empty
  task automatic test_queue_full();
    sample_keys(5'h1f, 2);
    sample_keys(5'h00, 2);
    sample_keys(5'h1f, 2);
    pop_keys(DEPTH);
  endtask

  task automatic random_mix(input int count);
    int start;
    int r;
    start = items_sent;
    while (items_sent - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        sample_keys(NUM_KEYS'($urandom_range(0, 31)), $urandom_range(2, 3));
      end else if (r < 85) begin
        pop_keys($urandom_range(1, 6));
      end else begin
        send_item(MODE_SAMPLE, NUM_KEYS'($urandom_range(0, 31)));
      end
    end
  endtask

  task automatic test_random();
    random_mix(150);
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    random_mix(60);
    idle_on = 1'b1;
  endtask

  // receiver holds off while samples keep coming, so the input stalls
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_cycles <= 300;
    sample_keys(5'b10101, 2);
    sample_keys(5'b01010, 2);
    random_mix(16);
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (idle_on) begin
      out_ready <= ($urandom_range(0, 99) >= 33);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    key_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (key_results_due.size() == 0) begin
        report_mismatch("transaction with no prediction", 1, 0);
      end else begin
        want = key_results_due.pop_front();
        if (key_code !== want.code) report_mismatch("key_code", key_code, want.code);
        if (keys_waiting !== want.waiting)
          report_mismatch("keys_waiting", keys_waiting, want.waiting);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_keypad_debounce_key_queue: errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pop_empty();
    test_single_press();
    test_unstable();
    test_queue_full();
    test_random();
    test_no_idle();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (key_results_due.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_keypad_debounce_key_queue: clean");
    end else begin
      $display("tb_keypad_debounce_key_queue: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/kdkq_pkg.sv
rtl/core/kdkq_ram.sv
rtl/core/kdkq_ctrl.sv
rtl/core/kdkq_dp.sv
rtl/core/keypad_debounce_key_queue.sv
sim/tb_keypad_debounce_key_queue.sv
